// ----- rtl/ntg_pkg.sv -----
// ----------------------------------------------------------------------------
// NTT twiddle generator package
// Shared types and fixed constants for the twiddle factor generator.
// ----------------------------------------------------------------------------
package ntg_pkg;

   localparam int INDEX_BITS     = 8;
   localparam int LOG2_SIZE_BITS = 4;
   localparam int CSR_INDEX_BITS = 2;

   localparam int MODULUS_RESET   = 3329;
   localparam int ROOT_RESET      = 17;
   localparam int PRESCALE_RESET  = 767;
   localparam int LOG2_SIZE_RESET = 7;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS,
      CSR_ROOT,
      CSR_PRESCALE,
      CSR_LOG2_SIZE
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQR,
      ST_MUL,
      ST_SCALE
   } state_type;

endpackage

// ----- rtl/ntt_twiddle_generator.sv -----
// ----------------------------------------------------------------------------
// NTT twiddle generator
// Returns zeta raised to the bit-reversed table index, times a prescale
// factor, modulo a programmable modulus, using one bit-serial modular
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Transfer
//   -------   -------------------------------------   --------------------------
//   request   start, busy, req_index                  start high, busy low
//   response  rsp_valid, rsp_twiddle                  rsp_valid high, one cycle
//   csr       csr_we, csr_index, csr_wdata            csr_we high
//
// Index zero (after masking) returns the root, else a zero modulus returns
// zero; the result appears in the cycle after the request transfer and busy
// stays low. Otherwise busy stays high while the bit-serial modular
// multiplier, which takes one operand bit per cycle, runs a square per index
// bit after the first, a multiply per set bit and a final prescale multiply.
// The result appears in the same cycle that busy falls; the next request may be
// taken in that same cycle. Reset is synchronous and restores the configuration
// registers and the sequencer state. The receiver cannot stall the response.
module ntt_twiddle_generator #(
   parameter int COEF_BITS     = 24,
   parameter int MAX_LOG2_SIZE = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ntg_pkg::INDEX_BITS-1:0]     req_index,
   output logic                               rsp_valid,
   output logic [COEF_BITS-1:0]               rsp_twiddle,
   input  logic                               csr_we,
   input  logic [ntg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]               csr_wdata
);

   localparam int IW  = MAX_LOG2_SIZE;
   localparam int KW  = (MAX_LOG2_SIZE > 1) ? $clog2(MAX_LOG2_SIZE) : 1;
   localparam int NBW = $clog2(MAX_LOG2_SIZE + 1);
   localparam int CW  = $clog2(COEF_BITS);
   localparam int TW  = COEF_BITS + 2;
   localparam int EW  = IW + ntg_pkg::INDEX_BITS;

   logic [COEF_BITS-1:0]                    modulus_ff;
   logic [COEF_BITS-1:0]                    root_ff;
   logic [COEF_BITS-1:0]                    prescale_ff;
   logic [ntg_pkg::LOG2_SIZE_BITS-1:0]      log2_size_ff;

   ntg_pkg::state_type                      state_ff, state_in;
   logic [KW-1:0]                           step_ff, step_in;
   logic [IW-1:0]                           idx_ff, idx_in;
   logic [NBW-1:0]                          nbits_ff, nbits_in;
   logic [COEF_BITS-1:0]                    op_a_ff, op_a_in;
   logic [COEF_BITS-1:0]                    op_b_ff, op_b_in;
   logic [COEF_BITS-1:0]                    prod_ff, prod_in;
   logic [CW-1:0]                           cnt_ff, cnt_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [COEF_BITS-1:0]                    rsp_twiddle_ff, rsp_twiddle_in;

   logic                                    accept;
   logic [EW-1:0]                           idx_ext;
   logic [IW-1:0]                           idx_start;
   logic [NBW-1:0]                          nbits_start;
   logic                                    trivial;
   logic                                    pass_done;
   logic                                    last_step;
   logic                                    start_last;
   logic [TW-1:0]                           sum;
   logic [TW-1:0]                           mod_x1;
   logic [TW-1:0]                           mod_x2;
   logic [COEF_BITS-1:0]                    prod_step;
   logic [COEF_BITS-1:0]                    acc_now;
   logic [COEF_BITS-1:0]                    acc_init;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= COEF_BITS'(ntg_pkg::MODULUS_RESET);
         root_ff      <= COEF_BITS'(ntg_pkg::ROOT_RESET);
         prescale_ff  <= COEF_BITS'(ntg_pkg::PRESCALE_RESET);
         log2_size_ff <= ntg_pkg::LOG2_SIZE_BITS'(ntg_pkg::LOG2_SIZE_RESET);
      end else if (csr_we) begin
         case (ntg_pkg::csr_index_type'(csr_index))
            ntg_pkg::CSR_MODULUS:   modulus_ff   <= csr_wdata;
            ntg_pkg::CSR_ROOT:      root_ff      <= csr_wdata;
            ntg_pkg::CSR_PRESCALE:  prescale_ff  <= csr_wdata;
            ntg_pkg::CSR_LOG2_SIZE:
               log2_size_ff <= csr_wdata[ntg_pkg::LOG2_SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign accept = start && !busy;
   assign idx_ext = EW'(req_index);

   always_comb begin
      if (log2_size_ff > ntg_pkg::LOG2_SIZE_BITS'(MAX_LOG2_SIZE)) begin
         nbits_start = NBW'(MAX_LOG2_SIZE);
      end else begin
         nbits_start = NBW'(log2_size_ff);
      end
      for (int k = 0; k < IW; k++) begin
         idx_start[k] = idx_ext[k] && (NBW'(k) < nbits_start);
      end
   end

   assign trivial    = (idx_start == '0) || (modulus_ff == '0);
   assign start_last = (nbits_start <= NBW'(1));
   assign last_step  = ((NBW'(step_ff) + NBW'(1)) >= nbits_ff);
   assign pass_done  = (cnt_ff == '0);
   assign acc_init   = (modulus_ff == COEF_BITS'(1)) ? '0 : COEF_BITS'(1);

   // One step of the interleaved modular multiplier: prod = 2 * prod + bit * a mod q.
   always_comb begin
      sum    = {1'b0, prod_ff, 1'b0} + (op_b_ff[COEF_BITS-1] ? TW'(op_a_ff) : '0);
      mod_x1 = TW'(modulus_ff);
      mod_x2 = {1'b0, modulus_ff, 1'b0};
      if (sum >= mod_x2) begin
         prod_step = COEF_BITS'(sum - mod_x2);
      end else if (sum >= mod_x1) begin
         prod_step = COEF_BITS'(sum - mod_x1);
      end else begin
         prod_step = COEF_BITS'(sum);
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ntg_pkg::ST_IDLE: begin
            if (accept && !trivial) begin
               step_in = '0;
               if (idx_start[0]) begin
                  state_in = ntg_pkg::ST_MUL;
               end else if (start_last) begin
                  state_in = ntg_pkg::ST_SCALE;
               end else begin
                  state_in = ntg_pkg::ST_SQR;
                  step_in  = KW'(1);
               end
            end
         end
         ntg_pkg::ST_SQR: begin
            if (pass_done) begin
               if (idx_ff[step_ff]) begin
                  state_in = ntg_pkg::ST_MUL;
               end else if (last_step) begin
                  state_in = ntg_pkg::ST_SCALE;
               end else begin
                  state_in = ntg_pkg::ST_SQR;
                  step_in  = KW'(NBW'(step_ff) + NBW'(1));
               end
            end
         end
         ntg_pkg::ST_MUL: begin
            if (pass_done) begin
               if (last_step) begin
                  state_in = ntg_pkg::ST_SCALE;
               end else begin
                  state_in = ntg_pkg::ST_SQR;
                  step_in  = KW'(NBW'(step_ff) + NBW'(1));
               end
            end
         end
         ntg_pkg::ST_SCALE: begin
            if (pass_done) begin
               state_in = ntg_pkg::ST_IDLE;
            end
         end
         default: state_in = ntg_pkg::ST_IDLE;
      endcase
   end

   // Datapath and result.
   always_comb begin
      idx_in         = idx_ff;
      nbits_in       = nbits_ff;
      op_a_in        = op_a_ff;
      op_b_in        = {op_b_ff[COEF_BITS-2:0], 1'b0};
      prod_in        = prod_step;
      cnt_in         = cnt_ff - CW'(1);
      rsp_valid_in   = 1'b0;
      rsp_twiddle_in = rsp_twiddle_ff;
      acc_now        = (state_ff == ntg_pkg::ST_IDLE) ? acc_init : prod_step;

      if (state_ff == ntg_pkg::ST_IDLE) begin
         idx_in   = idx_start;
         nbits_in = nbits_start;
         if (accept && trivial) begin
            rsp_valid_in   = 1'b1;
            rsp_twiddle_in = (idx_start == '0) ? root_ff : '0;
         end
      end

      if (state_ff == ntg_pkg::ST_SCALE && pass_done) begin
         rsp_valid_in   = 1'b1;
         rsp_twiddle_in = prod_step;
      end

      if (state_in != ntg_pkg::ST_IDLE
          && (state_ff == ntg_pkg::ST_IDLE || pass_done)) begin
         op_a_in = acc_now;
         prod_in = '0;
         cnt_in  = CW'(COEF_BITS - 1);
         case (state_in)
            ntg_pkg::ST_SQR:   op_b_in = acc_now;
            ntg_pkg::ST_MUL:   op_b_in = root_ff;
            ntg_pkg::ST_SCALE: op_b_in = prescale_ff;
            default:           op_b_in = acc_now;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntg_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      nbits_ff       <= nbits_in;
      op_a_ff        <= op_a_in;
      op_b_ff        <= op_b_in;
      prod_ff        <= prod_in;
      cnt_ff         <= cnt_in;
      rsp_twiddle_ff <= rsp_twiddle_in;
   end

   assign busy        = (state_ff != ntg_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_twiddle = rsp_twiddle_ff;

   // No response is shown while a computation is still running.
   assert property (@(posedge clock) disable iff (reset) busy |-> !rsp_valid_ff)
      else $error("response strobe while busy");

   // Leaving the busy state always delivers the computed response.
   assert property (@(posedge clock) disable iff (reset) $fell(busy) |-> rsp_valid_ff)
      else $error("computation ended without a response");

   // The sequencer never walks past the active index bits.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> (NBW'(step_ff) < nbits_ff))
      else $error("step counter beyond index width");

endmodule

// ----- tb/sv/ntt_twiddle_generator_checker.sv -----
// ----------------------------------------------------------------------------
// NTT twiddle generator checker
// Watches the request, response and CSR ports of the twiddle generator. It
// keeps its own copy of the registers and computes the twiddle for every
// accepted request. Each response is compared in order with those values.
// It reports the failure count and the number of responses still due.
// ----------------------------------------------------------------------------
module ntt_twiddle_generator_checker #(
   parameter int COEF_BITS     = 24,
   parameter int MAX_LOG2_SIZE = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [ntg_pkg::INDEX_BITS-1:0]     req_index,
   input  logic                               rsp_valid,
   input  logic [COEF_BITS-1:0]               rsp_twiddle,
   input  logic                               csr_we,
   input  logic [ntg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]               csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding
);

   logic [COEF_BITS-1:0]               modulus;
   logic [COEF_BITS-1:0]               root_of_unity;
   logic [COEF_BITS-1:0]               prescale;
   logic [ntg_pkg::LOG2_SIZE_BITS-1:0] log2_size;
   logic [COEF_BITS-1:0]               expected_twiddles[$];
   logic [COEF_BITS-1:0]               oldest_twiddle;

   function automatic logic [COEF_BITS-1:0] twiddle_for_index(
      input logic [ntg_pkg::INDEX_BITS-1:0] index
   );
      int          nbits;
      logic [63:0] masked;
      logic [63:0] powers[MAX_LOG2_SIZE];
      logic [63:0] acc;
      nbits = (log2_size > MAX_LOG2_SIZE) ? MAX_LOG2_SIZE : int'(log2_size);
      masked = 64'(index) & ((64'd1 << nbits) - 64'd1);
      if (masked == 64'd0) begin
         return root_of_unity;
      end
      if (modulus == '0) begin
         return '0;
      end
      // The repeated squares of the root are kept reduced; the root itself in the first entry is not.
      powers[0] = 64'(root_of_unity);
      for (int k = 1; k < nbits; k++) begin
         powers[k] = (powers[k - 1] * powers[k - 1]) % 64'(modulus);
      end
      acc = 64'd1;
      for (int k = 0; k < nbits; k++) begin
         if (masked[k]) begin
            acc = acc * powers[nbits - 1 - k];
         end
         acc = acc % 64'(modulus);
      end
      acc = (acc * 64'(prescale)) % 64'(modulus);
      return acc[COEF_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         modulus       <= COEF_BITS'(ntg_pkg::MODULUS_RESET);
         root_of_unity <= COEF_BITS'(ntg_pkg::ROOT_RESET);
         prescale      <= COEF_BITS'(ntg_pkg::PRESCALE_RESET);
         log2_size     <= ntg_pkg::LOG2_SIZE_BITS'(ntg_pkg::LOG2_SIZE_RESET);
         expected_twiddles.delete();
         fail_count    <= 0;
         outstanding   <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ntg_pkg::CSR_MODULUS:   modulus       <= csr_wdata;
               ntg_pkg::CSR_ROOT:      root_of_unity <= csr_wdata;
               ntg_pkg::CSR_PRESCALE:  prescale      <= csr_wdata;
               ntg_pkg::CSR_LOG2_SIZE:
                  log2_size <= csr_wdata[ntg_pkg::LOG2_SIZE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_twiddles.size() == 0) begin
               $error("twiddle: expected none, actual %0d", rsp_twiddle);
               fail_count <= fail_count + 1;
            end else begin
               oldest_twiddle = expected_twiddles.pop_front();
               if (rsp_twiddle !== oldest_twiddle) begin
                  $error("twiddle: expected %0d, actual %0d", oldest_twiddle, rsp_twiddle);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            expected_twiddles.push_back(twiddle_for_index(req_index));
         end
         outstanding <= expected_twiddles.size();
      end
   end

endmodule

// ----- tb/sv/ntt_twiddle_generator_test.sv -----
// ----------------------------------------------------------------------------
// NTT twiddle generator test
// Drives table indexes into the twiddle generator under a range of register
// settings. A short directed part covers the field extremes and the corner
// cases: masked index zero, zero modulus, modulus one and two, zero and
// oversized table sizes, and a root or prescale above the modulus. Random
// phases follow with the sender idling at varied rates.
// The checker beside the block judges every response.
// ----------------------------------------------------------------------------
module ntt_twiddle_generator_test;

   localparam int COEF_BITS       = 24;
   localparam int MAX_LOG2_SIZE   = 8;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int RANDOM_PHASES   = 16;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int DRAIN_CYCLES    = 400;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               start       = 1'b0;
   logic                               busy;
   logic [ntg_pkg::INDEX_BITS-1:0]     req_index   = '0;
   logic                               rsp_valid;
   logic [COEF_BITS-1:0]               rsp_twiddle;
   logic                               csr_we      = 1'b0;
   logic [ntg_pkg::CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [COEF_BITS-1:0]               csr_wdata   = '0;
   int                                 fail_count;
   int                                 outstanding;
   int unsigned                        cycle_count = 0;
   int                                 idle_percent = 26;

   always #4 clock = ~clock;

   ntt_twiddle_generator #(
      .COEF_BITS     (COEF_BITS),
      .MAX_LOG2_SIZE (MAX_LOG2_SIZE)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_index   (req_index),
      .rsp_valid   (rsp_valid),
      .rsp_twiddle (rsp_twiddle),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   ntt_twiddle_generator_checker #(
      .COEF_BITS     (COEF_BITS),
      .MAX_LOG2_SIZE (MAX_LOG2_SIZE)
   ) twiddle_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_index   (req_index),
      .rsp_valid   (rsp_valid),
      .rsp_twiddle (rsp_twiddle),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Start stays high after a transfer when the next request follows at once.
   task automatic send_index(input logic [ntg_pkg::INDEX_BITS-1:0] index);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_index <= index;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(
      input ntg_pkg::csr_index_type which,
      input logic [COEF_BITS-1:0]   value
   );
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(
      input logic [COEF_BITS-1:0] modulus_word,
      input logic [COEF_BITS-1:0] root_word,
      input logic [COEF_BITS-1:0] prescale_word,
      input logic [COEF_BITS-1:0] size_word
   );
      wait_idle();
      write_reg(ntg_pkg::CSR_MODULUS, modulus_word);
      write_reg(ntg_pkg::CSR_ROOT, root_word);
      write_reg(ntg_pkg::CSR_PRESCALE, prescale_word);
      write_reg(ntg_pkg::CSR_LOG2_SIZE, size_word);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [COEF_BITS-1:0]               modulus_word;
      logic [COEF_BITS-1:0]               root_word;
      logic [COEF_BITS-1:0]               prescale_word;
      logic [COEF_BITS-1:0]               size_word;
      logic [ntg_pkg::LOG2_SIZE_BITS-1:0] log2_size;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_index(8'd0);
      send_index(8'd1);
      send_index(8'd127);
      send_index(8'd128);
      send_index(8'd255);
      send_index(8'd85);

      load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_index(8'd255);
      send_index(8'd1);
      send_index(8'd0);

      load_settings(24'd0, 24'd12345, 24'd7, 24'd8);
      send_index(8'd0);
      send_index(8'd200);

      load_settings(24'd1, 24'd9, 24'd9, 24'd4);
      send_index(8'd15);

      load_settings(24'd2, 24'd3, 24'd1, 24'd3);
      send_index(8'd5);
      send_index(8'd7);

      load_settings(24'd97, 24'd5, 24'd11, 24'd0);
      send_index(8'd255);

      load_settings(24'd17, 24'd100, 24'd40, 24'd1);
      send_index(8'd1);
      send_index(8'd0);

      load_settings(24'd3, 24'd0, 24'd0, 24'd2);
      send_index(8'd3);
      send_index(8'd2);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(9))
            0: modulus_word = 24'd3329;
            1: modulus_word = 24'd7681;
            2: modulus_word = 24'd12289;
            3: modulus_word = 24'd8380417;
            4: modulus_word = COEF_BITS'($urandom_range(2));
            5, 6: modulus_word = COEF_BITS'($urandom_range(255, 3));
            default: modulus_word = COEF_BITS'($urandom_range(24'hFFFFFF, 3));
         endcase
         if (modulus_word != '0 && $urandom_range(7) != 0) begin
            root_word     = COEF_BITS'($urandom_range(modulus_word - 1));
            prescale_word = COEF_BITS'($urandom_range(modulus_word - 1));
         end else begin
            root_word     = COEF_BITS'($urandom());
            prescale_word = COEF_BITS'($urandom());
         end
         case ($urandom_range(9))
            7, 8: log2_size = ntg_pkg::LOG2_SIZE_BITS'($urandom_range(MAX_LOG2_SIZE, 5));
            9: log2_size = ($urandom_range(1) == 0)
                  ? '0 : ntg_pkg::LOG2_SIZE_BITS'($urandom_range(15, 9));
            default: log2_size = ntg_pkg::LOG2_SIZE_BITS'($urandom_range(4, 1));
         endcase
         size_word = COEF_BITS'($urandom());
         size_word[ntg_pkg::LOG2_SIZE_BITS-1:0] = log2_size;
         load_settings(modulus_word, root_word, prescale_word, size_word);

         if (phase < 6) begin
            idle_percent = 26;
         end else if (phase < 11) begin
            idle_percent = 71;
         end else begin
            idle_percent = 0;
         end
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            send_index(ntg_pkg::INDEX_BITS'($urandom_range(255)));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ntg_pkg.sv
rtl/ntt_twiddle_generator.sv
tb/sv/ntt_twiddle_generator_checker.sv
tb/sv/ntt_twiddle_generator_test.sv
